// ===== design/dds_pkg.sv =====
package dds_pkg;

  localparam int unsigned RATE_W    = 17;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned SMP_W     = 15;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned FRAMES_W  = 23;
  localparam int unsigned PROD_W    = RATE_W + MS_W;
  localparam int unsigned DIV_W     = FREQ_W + PHASE_W;
  localparam int unsigned REM_W     = RATE_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // frames = floor(floor(prod / 8) / 125); ceil(2^37 / 125) is exact below 2^30
  localparam int unsigned DIV8_W       = PROD_W - 3;
  localparam int unsigned RECIP_W      = 31;
  localparam int unsigned RECIP_SH     = 37;
  localparam int unsigned RECIP_PROD_W = DIV8_W + RECIP_W;

  localparam logic [RATE_W-1:0]   RATE_RESET = RATE_W'(16000);
  localparam logic [RATE_W-1:0]   MS_PER_S   = RATE_W'(1000);
  localparam logic [RECIP_W-1:0]  RECIP_125  = RECIP_W'(1099511628);
  localparam logic [FREQ_W-1:0]   FREQ_MIN   = FREQ_W'(20);
  localparam logic [FREQ_W-1:0]   FREQ_MAX   = FREQ_W'(8000);
  localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;
  localparam longint              AMPLITUDE  = 16000;
  localparam longint              HALF_PI_Q30 = 64'd1686629713;
  localparam longint              ONE_Q30    = 64'd1 << 30;

  typedef enum logic [KIND_W-1:0] {
    KIND_IDLE   = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REFUSE = 2'd3
  } kind_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_FRM,
    ST_DIVI,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic  cap_in;
    logic  mul_go;
    logic  div_start;
    logic  frm_store;
    logic  commit;
    logic  tick_step;
    logic  res_load;
    kind_e res_kind;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic op_start;
    logic start_ok;
    logic frames_zero;
    logic div_idle;
  } sts_t;

  // first-quadrant sine magnitude, Taylor series in Q30, elaboration only
  function automatic logic [SMP_W-1:0] quarter_mag(int unsigned q, int unsigned sb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    longint      m;
    logic [63:0] mag;
    m = longint'(1) << (sb - 2);
    if (q == 0) begin
      return '0;
    end
    if (longint'(q) >= m) begin
      return SMP_W'(AMPLITUDE);
    end
    x  = (64'(q) * HALF_PI_Q30) >> (sb - 2);
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    t = ((t * x2) >> 30) / 64'd6;   s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd20;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd42;  s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd72;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd110; s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd156; s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd210; s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd272; s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd342; s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd420; s = s + longint'(t);
    if (s < 0) begin
      s = 0;
    end
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    mag = (64'(s) * 64'(AMPLITUDE)) >> 30;
    return mag[SMP_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sine_entry(int unsigned i, int unsigned sb);
    int unsigned m;
    m = 1 << (sb - 2);
    if (i < m) begin
      return $signed(quarter_mag(i, sb));
    end else if (i < 2 * m) begin
      return $signed(quarter_mag(2 * m - i, sb));
    end else if (i < 3 * m) begin
      return -$signed(quarter_mag(i - 2 * m, sb));
    end
    return -$signed(quarter_mag(4 * m - i, sb));
  endfunction

endpackage

// ===== design/dds_req_if.sv =====
interface dds_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [dds_pkg::FREQ_W-1:0]    tone_freq;
  logic [dds_pkg::MS_W-1:0]      tone_ms;

  modport source (output valid, output opcode, output tone_freq, output tone_ms,
                  input ready);
  modport sink   (input valid, input opcode, input tone_freq, input tone_ms,
                  output ready);
endinterface

// ===== design/dds_rsp_if.sv =====
interface dds_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [dds_pkg::KIND_W-1:0]       result_kind;
  logic signed [dds_pkg::SMP_W-1:0] left_sample;
  logic signed [dds_pkg::SMP_W-1:0] right_sample;
  logic                             last_frame;

  modport source (output valid, output result_kind, output left_sample,
                  output right_sample, output last_frame, input ready);
  modport sink   (input valid, input result_kind, input left_sample,
                  input right_sample, input last_frame, output ready);
endinterface

// ===== design/dds_cfg_if.sv =====
interface dds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dds_pkg::RATE_W-1:0] frame_rate;

  modport source (output valid, output frame_rate, input ready);
  modport sink   (input valid, input frame_rate, output ready);
endinterface

// ===== design/dds_div.sv =====
module dds_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dds_pkg::DIV_W-1:0]         dividend_i,
  input  logic [dds_pkg::RATE_W-1:0]        divisor_i,
  output logic                              idle_o,
  output logic [dds_pkg::PHASE_W-1:0]       quot_o
);

  logic                              busy_q, busy_d;
  logic [dds_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [dds_pkg::DIV_W-1:0]         dvd_q;
  logic [dds_pkg::RATE_W-1:0]        dvs_q;
  logic [dds_pkg::RATE_W-1:0]        rem_q;
  logic [dds_pkg::PHASE_W-1:0]       quo_q;
  logic [dds_pkg::REM_W-1:0]         rem_sh;
  logic [dds_pkg::REM_W-1:0]         rem_sub;
  logic                              ge;

  assign rem_sh  = {rem_q, dvd_q[dds_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = dds_pkg::DIV_CNT_W'(dds_pkg::DIV_W);
    end else if (busy_q) begin
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != dds_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[dds_pkg::DIV_W-2:0], 1'b0};
      rem_q <= rem_sub[dds_pkg::RATE_W-1:0];
      quo_q <= {quo_q[dds_pkg::PHASE_W-2:0], ge};
    end
  end

  assign idle_o = !busy_q;
  assign quot_o = quo_q;

endmodule

// ===== design/dds_ctrl.sv =====
module dds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  dds_pkg::sts_t sts_i,
  output dds_pkg::cmd_t cmd_o
);

  dds_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dds_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = dds_pkg::ST_DECODE;
      end
      dds_pkg::ST_DECODE: begin
        if (sts_i.op_start && sts_i.start_ok) state_d = dds_pkg::ST_MUL;
        else state_d = dds_pkg::ST_EMIT;
      end
      dds_pkg::ST_MUL: state_d = dds_pkg::ST_FRM;
      dds_pkg::ST_FRM: state_d = dds_pkg::ST_DIVI;
      dds_pkg::ST_DIVI: begin
        if (sts_i.div_idle) state_d = dds_pkg::ST_EMIT;
      end
      dds_pkg::ST_EMIT: begin
        if (slot_free) state_d = dds_pkg::ST_IDLE;
      end
      default: state_d = dds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.res_kind = dds_pkg::KIND_IDLE;
    req_ready_o = 1'b0;
    unique case (state_q)
      dds_pkg::ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.cap_in = req_valid_i;
      end
      dds_pkg::ST_DECODE: begin
        if (sts_i.op_start) begin
          if (!sts_i.start_ok) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = dds_pkg::KIND_REFUSE;
          end
        end else if (sts_i.frames_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = dds_pkg::KIND_IDLE;
        end else begin
          cmd_o.res_load  = 1'b1;
          cmd_o.res_kind  = dds_pkg::KIND_FRAME;
          cmd_o.tick_step = 1'b1;
        end
      end
      dds_pkg::ST_MUL: begin
        cmd_o.mul_go    = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      dds_pkg::ST_FRM: cmd_o.frm_store = 1'b1;
      dds_pkg::ST_DIVI: begin
        if (sts_i.div_idle) begin
          cmd_o.commit   = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = dds_pkg::KIND_ACCEPT;
        end
      end
      dds_pkg::ST_EMIT: cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dds_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> sts_i.div_idle)
    else $error("divider started while busy");

  a_tick_has_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_step |-> !sts_i.frames_zero)
    else $error("frame produced with no frames left");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dds_pkg::ST_EMIT))
    else $error("response raised outside emit");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dds_pkg::ST_EMIT && state_d != dds_pkg::ST_EMIT) |-> cmd_o.out_load)
    else $error("emit left without loading response");
`endif

endmodule

// ===== design/dds_dp.sv =====
module dds_dp #(
  parameter int unsigned SINE_BITS = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dds_pkg::RATE_W-1:0]       cfg_rate_i,
  input  logic                             opcode_i,
  input  logic [dds_pkg::FREQ_W-1:0]       tone_freq_i,
  input  logic [dds_pkg::MS_W-1:0]         tone_ms_i,
  input  dds_pkg::cmd_t                    cmd_i,
  output dds_pkg::sts_t                    sts_o,
  output logic [dds_pkg::KIND_W-1:0]       result_kind_o,
  output logic signed [dds_pkg::SMP_W-1:0] sample_o,
  output logic                             last_frame_o
);

  localparam int unsigned SINE_SIZE = 1 << SINE_BITS;

  logic [dds_pkg::RATE_W-1:0]        rate_q;
  logic                              op_q;
  logic [dds_pkg::FREQ_W-1:0]        freq_q;
  logic [dds_pkg::MS_W-1:0]          ms_q;
  logic [dds_pkg::PROD_W-1:0]        prod_q;
  logic [dds_pkg::RECIP_PROD_W-1:0]  frm_prod;
  logic [dds_pkg::FRAMES_W:0]        frm_quo;
  logic [dds_pkg::FRAMES_W-1:0]      frames_new_q;
  logic [dds_pkg::PHASE_W-1:0]       phase_acc_q, phase_inc_q;
  logic [dds_pkg::FRAMES_W-1:0]      frames_left_q;
  logic signed [dds_pkg::SMP_W-1:0]  rom [SINE_SIZE];
  logic signed [dds_pkg::SMP_W-1:0]  rom_q;
  dds_pkg::kind_e                    res_kind_q;
  logic signed [dds_pkg::SMP_W-1:0]  res_smp_q;
  logic                              res_last_q;
  logic [dds_pkg::KIND_W-1:0]        out_kind_q;
  logic signed [dds_pkg::SMP_W-1:0]  out_smp_q;
  logic                              out_last_q;
  logic [dds_pkg::DIV_W-1:0]         div_dvd;
  logic [dds_pkg::RATE_W-1:0]        div_dvs;
  logic                              div_idle;
  logic [dds_pkg::PHASE_W-1:0]       div_quo;

  for (genvar g = 0; g < SINE_SIZE; g++) begin : g_rom
    localparam logic signed [dds_pkg::SMP_W-1:0] V = dds_pkg::sine_entry(g, SINE_BITS);
    assign rom[g] = V;
  end

  always_ff @(posedge clk_i) begin
    rom_q <= rom[phase_acc_q[dds_pkg::PHASE_W-1 -: SINE_BITS]];
  end

  assign div_dvd = {freq_q, dds_pkg::PHASE_W'(0)};
  assign div_dvs = rate_q;

  dds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .idle_o     (div_idle),
    .quot_o     (div_quo)
  );

  // frame count: drop 3 bits, then multiply by the reciprocal of 125
  assign frm_prod = dds_pkg::RECIP_PROD_W'(prod_q[dds_pkg::PROD_W-1:3]) *
                    dds_pkg::RECIP_PROD_W'(dds_pkg::RECIP_125);
  assign frm_quo  = frm_prod[dds_pkg::RECIP_SH +: (dds_pkg::FRAMES_W + 1)];

  always_comb begin
    sts_o.op_start    = (op_q == dds_pkg::OP_START);
    sts_o.start_ok    = (freq_q >= dds_pkg::FREQ_MIN) && (freq_q <= dds_pkg::FREQ_MAX) &&
                        (ms_q != '0) && (rate_q != '0);
    sts_o.frames_zero = (frames_left_q == '0);
    sts_o.div_idle    = div_idle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q        <= dds_pkg::RATE_RESET;
      phase_acc_q   <= '0;
      phase_inc_q   <= '0;
      frames_left_q <= '0;
    end else begin
      if (cfg_we_i) rate_q <= cfg_rate_i;
      if (cmd_i.commit) begin
        phase_acc_q   <= '0;
        phase_inc_q   <= div_quo;
        frames_left_q <= frames_new_q;
      end else if (cmd_i.tick_step) begin
        phase_acc_q   <= phase_acc_q + phase_inc_q;
        frames_left_q <= frames_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q   <= opcode_i;
      freq_q <= tone_freq_i;
      ms_q   <= tone_ms_i;
    end
    if (cmd_i.mul_go) prod_q <= dds_pkg::PROD_W'(rate_q) * dds_pkg::PROD_W'(ms_q);
    if (cmd_i.frm_store) begin
      frames_new_q <= frm_quo[dds_pkg::FRAMES_W] ? dds_pkg::FRAMES_MAX
                                                 : frm_quo[dds_pkg::FRAMES_W-1:0];
    end
    if (cmd_i.res_load) begin
      res_kind_q <= cmd_i.res_kind;
      res_smp_q  <= cmd_i.tick_step ? rom_q : '0;
      res_last_q <= cmd_i.tick_step && (frames_left_q == dds_pkg::FRAMES_W'(1));
    end
    if (cmd_i.out_load) begin
      out_kind_q <= res_kind_q;
      out_smp_q  <= res_smp_q;
      out_last_q <= res_last_q;
    end
  end

  assign result_kind_o = out_kind_q;
  assign sample_o      = out_smp_q;
  assign last_frame_o  = out_last_q;

endmodule

// ===== design/dds_sine_tone_generator.sv =====
// Tick and refused start: decoded and loaded to the output before a new request is taken.
// Accepted start: the response waits on the 48-step radix-2 divider for the phase step;
// the frame count is a reciprocal multiply that runs alongside it.
// Sine samples come from a registered constant ROM of 2^SINE_BITS entries.
// A held response stalls the input until it is taken.
// Reset: async active low; phase, step and frame count clear (idle),
// frame rate returns to 16000, no response pending.
module dds_sine_tone_generator #(
  parameter int unsigned SINE_BITS = 9
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dds_cfg_if.sink   cfg_i,
  dds_req_if.sink   req_i,
  dds_rsp_if.source rsp_o
);

  dds_pkg::cmd_t                    cmd;
  dds_pkg::sts_t                    sts;
  logic                             req_ready;
  logic                             rsp_valid;
  logic [dds_pkg::KIND_W-1:0]       kind;
  logic signed [dds_pkg::SMP_W-1:0] sample;
  logic                             last_frame;

  dds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dds_dp #(
    .SINE_BITS (SINE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_rate_i    (cfg_i.frame_rate),
    .opcode_i      (req_i.opcode),
    .tone_freq_i   (req_i.tone_freq),
    .tone_ms_i     (req_i.tone_ms),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_kind_o (kind),
    .sample_o      (sample),
    .last_frame_o  (last_frame)
  );

  assign cfg_i.ready        = 1'b1;
  assign req_i.ready        = req_ready;
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.result_kind  = kind;
  assign rsp_o.left_sample  = sample;
  assign rsp_o.right_sample = sample;
  assign rsp_o.last_frame   = last_frame;

endmodule

// ===== verif/dds_sine_tone_generator_tb.sv =====
`timescale 1ns / 1ps

module dds_sine_tone_generator_tb;

  localparam int unsigned SINE_BITS    = 9;
  localparam int unsigned SINE_SIZE    = 1 << SINE_BITS;
  localparam int unsigned QUARTER      = SINE_SIZE / 4;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_GAP   = 20;
  localparam int unsigned SEG_ITEMS    = 125;
  localparam int unsigned MAX_TICKS    = 100;

  typedef struct packed {
    dds_pkg::kind_e                   kind;
    logic signed [dds_pkg::SMP_W-1:0] smp;
    logic                             last;
  } tone_rsp_t;

  class tone_scoreboard;
    logic signed [dds_pkg::SMP_W-1:0] sine_tab [SINE_SIZE];
    logic [dds_pkg::PHASE_W-1:0]      phase;
    logic [dds_pkg::PHASE_W-1:0]      step;
    logic [dds_pkg::FRAMES_W-1:0]     frames_left;
    logic [dds_pkg::RATE_W-1:0]       rate;
    tone_rsp_t                        tone_q [$];
    int                               errors;

    function new();
      int unsigned i;
      for (i = 0; i < SINE_SIZE; i++) begin
        if (i < QUARTER) begin
          sine_tab[i] = dds_pkg::SMP_W'(quadrant_mag(i));
        end else if (i < 2 * QUARTER) begin
          sine_tab[i] = dds_pkg::SMP_W'(quadrant_mag(2 * QUARTER - i));
        end else if (i < 3 * QUARTER) begin
          sine_tab[i] = dds_pkg::SMP_W'(-quadrant_mag(i - 2 * QUARTER));
        end else begin
          sine_tab[i] = dds_pkg::SMP_W'(-quadrant_mag(4 * QUARTER - i));
        end
      end
      phase       = '0;
      step        = '0;
      frames_left = '0;
      rate        = dds_pkg::RATE_RESET;
      errors      = 0;
    endfunction

    // first quadrant, Q30 Taylor series, clamped to [0, 1]
    function longint quadrant_mag(int unsigned q);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint          acc;
      int              k;
      if (q == 0) return 0;
      if (q >= QUARTER) return dds_pkg::AMPLITUDE;
      x   = (longint'(q) * dds_pkg::HALF_PI_Q30) / QUARTER;
      x2  = (x * x) >> 30;
      t   = x;
      acc = longint'(x);
      for (k = 1; k <= 10; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(t);
        end else begin
          acc = acc + longint'(t);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > dds_pkg::ONE_Q30) acc = dds_pkg::ONE_Q30;
      return (acc * dds_pkg::AMPLITUDE) >>> 30;
    endfunction

    function void set_rate(logic [dds_pkg::RATE_W-1:0] r);
      rate = r;
    endfunction

    function int pending();
      return tone_q.size();
    endfunction

    function void note_request(dds_pkg::op_e op, logic [dds_pkg::FREQ_W-1:0] freq,
                               logic [dds_pkg::MS_W-1:0] ms);
      tone_rsp_t       r;
      longint unsigned frames;
      r      = '0;
      r.kind = dds_pkg::KIND_IDLE;
      if (op == dds_pkg::OP_START) begin
        if (freq < dds_pkg::FREQ_MIN || freq > dds_pkg::FREQ_MAX || ms == 0 || rate == 0)
        begin
          r.kind = dds_pkg::KIND_REFUSE;
        end else begin
          frames = (64'(rate) * 64'(ms)) / 64'(dds_pkg::MS_PER_S);
          if (frames > 64'(dds_pkg::FRAMES_MAX)) frames = 64'(dds_pkg::FRAMES_MAX);
          step        = dds_pkg::PHASE_W'((64'(freq) << 32) / 64'(rate));
          frames_left = dds_pkg::FRAMES_W'(frames);
          phase       = '0;
          r.kind      = dds_pkg::KIND_ACCEPT;
        end
      end else if (frames_left != 0) begin
        r.smp       = sine_tab[phase[dds_pkg::PHASE_W-1 -: SINE_BITS]];
        phase       = phase + step;
        frames_left = frames_left - 1'b1;
        r.last      = (frames_left == 0);
        r.kind      = dds_pkg::KIND_FRAME;
      end
      tone_q.push_back(r);
    endfunction

    function void check_response(logic [dds_pkg::KIND_W-1:0] kind,
                                 logic signed [dds_pkg::SMP_W-1:0] left,
                                 logic signed [dds_pkg::SMP_W-1:0] right, logic last);
      tone_rsp_t e;
      if (tone_q.size() == 0) begin
        $error("response with no request pending: result_kind %0d", kind);
        errors++;
        return;
      end
      e = tone_q.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (left !== e.smp) begin
        $error("left_sample: expected %0d, got %0d", e.smp, left);
        errors++;
      end
      if (right !== e.smp) begin
        $error("right_sample: expected %0d, got %0d", e.smp, right);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_frame: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dds_cfg_if cfg_if ();
  dds_req_if req_if ();
  dds_rsp_if rsp_if ();

  dds_sine_tone_generator #(
    .SINE_BITS(SINE_BITS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  tone_scoreboard sb;
  int             snd_idle_pct;
  int             rsp_idle_pct;
  bit             hold_rsp;
  int unsigned    items_sent;
  int unsigned    cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** dds_sine_tone_generator: FAILED **");
    $finish;
  end

  task automatic send_req(dds_pkg::op_e op, logic [dds_pkg::FREQ_W-1:0] freq,
                          logic [dds_pkg::MS_W-1:0] ms);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.tone_freq <= freq;
    req_if.tone_ms   <= ms;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(op, freq, ms);
    items_sent++;
  endtask

  task automatic send_tick();
    send_req(dds_pkg::OP_TICK, dds_pkg::FREQ_W'($urandom), dds_pkg::MS_W'($urandom));
  endtask

  task automatic drain_tone();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_rate(logic [dds_pkg::RATE_W-1:0] r);
    cfg_if.valid      <= 1'b1;
    cfg_if.frame_rate <= r;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_rate(r);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly well-formed tones with a run of ticks, some raw noise requests
  task automatic play_segment(logic [dds_pkg::RATE_W-1:0] r, bit with_hold);
    int unsigned                 target;
    int                          ms_hi;
    longint unsigned             frames;
    int                          ticks;
    int                          n;
    bit                          hold_done;
    logic [dds_pkg::FREQ_W-1:0]  f;
    logic [dds_pkg::MS_W-1:0]    ms;
    target    = items_sent + SEG_ITEMS;
    hold_done = 1'b0;
    ms_hi     = (r == 0) ? 8 : 12000 / int'(r);
    if (ms_hi < 1) ms_hi = 1;
    send_req(dds_pkg::OP_START,
             dds_pkg::FREQ_W'($urandom_range(dds_pkg::FREQ_MAX, dds_pkg::FREQ_MIN)), '1);
    while (items_sent < target) begin
      if (with_hold && !hold_done && items_sent >= target - SEG_ITEMS / 2) begin
        hold_rsp  = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(3) == 0) begin
          f = $urandom_range(1) ? dds_pkg::FREQ_MIN : dds_pkg::FREQ_MAX;
        end else begin
          f = dds_pkg::FREQ_W'($urandom_range(dds_pkg::FREQ_MAX, dds_pkg::FREQ_MIN));
        end
        if ($urandom_range(9) == 0) begin
          ms = dds_pkg::MS_W'($urandom);
        end else begin
          ms = dds_pkg::MS_W'($urandom_range(ms_hi, 1));
        end
        frames = (64'(r) * 64'(ms)) / 64'(dds_pkg::MS_PER_S);
        ticks  = (frames > MAX_TICKS) ? MAX_TICKS : int'(frames);
        ticks  = ticks + $urandom_range(2);
        send_req(dds_pkg::OP_START, f, ms);
        for (n = 0; n < ticks; n++) send_tick();
      end else begin
        send_req(dds_pkg::op_e'($urandom_range(1)), dds_pkg::FREQ_W'($urandom),
                 dds_pkg::MS_W'($urandom));
      end
    end
  endtask

  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response(rsp_if.result_kind, rsp_if.left_sample, rsp_if.right_sample,
                          rsp_if.last_frame);
      end
      if (hold_rsp) begin
        hold_left = HOLD_CYCLES;
        hold_rsp  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [dds_pkg::RATE_W-1:0] rates [9];
    int                         seg;
    sb                 = new();
    snd_idle_pct       = 0;
    rsp_idle_pct       = 0;
    hold_rsp           = 1'b0;
    items_sent         = 0;
    rates              = '{17'd8000, 17'd96000, 17'd7, 17'd131071, 17'd44100, 17'd0,
                           17'd48000, 17'd8000, 17'd22050};
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= dds_pkg::OP_TICK;
    req_if.tone_freq   <= '0;
    req_if.tone_ms     <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.frame_rate  <= dds_pkg::RATE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refusals, quadrant points, refusal during a tone, replacement
    send_req(dds_pkg::OP_TICK, '1, '1);
    send_req(dds_pkg::OP_START, dds_pkg::FREQ_MIN - 1'b1, 16'd100);
    send_req(dds_pkg::OP_START, dds_pkg::FREQ_MAX + 1'b1, 16'd100);
    send_req(dds_pkg::OP_START, 16'd440, '0);
    send_req(dds_pkg::OP_START, '1, '1);
    send_req(dds_pkg::OP_START, '0, '0);
    send_req(dds_pkg::OP_START, 16'd4000, 16'd1);
    repeat (5) send_tick();
    send_req(dds_pkg::OP_START, 16'd10, 16'd5);
    repeat (2) send_tick();
    send_req(dds_pkg::OP_START, dds_pkg::FREQ_MAX, '1);
    repeat (2) send_tick();
    send_req(dds_pkg::OP_START, dds_pkg::FREQ_MIN, 16'd1);
    repeat (3) send_tick();

    for (seg = 0; seg < 9; seg++) begin
      drain_tone();
      write_rate(rates[seg]);
      case (seg / 3)
        0: begin
          snd_idle_pct = 33;
          rsp_idle_pct = 65;
        end
        1: begin
          snd_idle_pct = 65;
          rsp_idle_pct = 33;
        end
        default: begin
          snd_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      play_segment(rates[seg], seg == 6);
    end

    drain_tone();
    if (sb.errors == 0) begin
      $display("** dds_sine_tone_generator: PASSED **");
    end else begin
      $display("** dds_sine_tone_generator: FAILED **");
    end
    $finish;
  end

endmodule
